// ===== design/svgcpb_pkg.sv =====
package svgcpb_pkg;

	localparam int unsigned COEF_FRAC_BITS = 12;

	localparam int unsigned PIX_W     = 8;
	localparam int unsigned COEF_W    = 24;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned LANES     = 4;

	localparam logic [MODE_W-1:0] MODE_OVER  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_IN    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OUT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ATOP  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_XOR   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ARITH = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PRODUCT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET  = 3'd4;

	// arithmetic channel value: floor(N / 255^2), N below 2^41 in magnitude
	localparam int unsigned DIV_D     = 65025;
	localparam int unsigned DIV_W     = 16;
	localparam int unsigned X_W       = 42;
	localparam int unsigned X_HALF    = X_W / 2;
	localparam int unsigned RECIP_W   = 27;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << X_W) / DIV_D);
	localparam int unsigned Q_W       = 27;
	localparam int unsigned V_W       = 27;

	localparam int unsigned LANE_LAT  = 9;
	localparam int unsigned MERGE_LAT = 4;

	localparam int unsigned QUEUE_DEPTH = 32;
	localparam int unsigned QUEUE_AW    = 5;

	typedef struct packed {
		logic valid;
		logic arith;
	} ctrl_t;

	typedef struct packed {
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

endpackage

// ===== design/svgcpb_lane.sv =====
module svgcpb_lane (
	input  logic                                   clk,
	input  logic [svgcpb_pkg::PIX_W-1:0]           chan_a,
	input  logic [svgcpb_pkg::PIX_W-1:0]           chan_b,
	input  logic [svgcpb_pkg::PIX_W-1:0]           alpha_a,
	input  logic [svgcpb_pkg::PIX_W-1:0]           alpha_b,
	input  logic                                   in_region,
	input  logic [svgcpb_pkg::MODE_W-1:0]          mode,
	input  logic signed [svgcpb_pkg::COEF_W-1:0]   k_product,
	input  logic signed [svgcpb_pkg::COEF_W-1:0]   k_first,
	input  logic signed [svgcpb_pkg::COEF_W-1:0]   k_second,
	input  logic signed [svgcpb_pkg::COEF_W-1:0]   k_offset,
	output logic [svgcpb_pkg::PIX_W-1:0]           blend,
	output logic signed [svgcpb_pkg::V_W-1:0]      arith_val
);

	localparam int unsigned PW       = svgcpb_pkg::PIX_W;
	localparam int unsigned LIN_W    = svgcpb_pkg::COEF_W + PW + 2;
	localparam int unsigned LIN255_W = LIN_W + 8;
	localparam int unsigned PROD_W   = svgcpb_pkg::COEF_W + 2 * PW + 1;
	localparam int unsigned OFF_W    = svgcpb_pkg::COEF_W + svgcpb_pkg::DIV_W + 1;
	localparam int unsigned N_W      = LIN255_W + 2;
	localparam int unsigned X_W      = svgcpb_pkg::X_W;
	localparam int unsigned X_HALF   = svgcpb_pkg::X_HALF;
	localparam int unsigned PP_W     = X_W - X_HALF + svgcpb_pkg::RECIP_W;
	localparam int unsigned EST_W    = PP_W + X_HALF + 1;
	localparam int unsigned Q_W      = svgcpb_pkg::Q_W;
	localparam int unsigned QD_W     = Q_W + svgcpb_pkg::DIV_W;
	localparam int unsigned PD_DLY   = svgcpb_pkg::LANE_LAT - 3;
	localparam logic [svgcpb_pkg::DIV_W-1:0] DIV_D16 = svgcpb_pkg::DIV_W'(svgcpb_pkg::DIV_D);

	function automatic logic [PW-1:0] div255_round(input logic [2*PW-1:0] p);
		logic [2*PW:0] t;
		logic [2*PW:0] s;
		t = {1'b0, p} + (2*PW+1)'(128);
		s = t + (t >> PW);
		return s[2*PW-1:PW];
	endfunction

	logic [PW-1:0] inv_alpha_a, inv_alpha_b;
	assign inv_alpha_a = 8'hFF - alpha_a;
	assign inv_alpha_b = 8'hFF - alpha_b;

	// stage 1: channel products
	logic [2*PW-1:0]          ab_s1, p_a_ba_s1, p_a_ib_s1, p_b_ia_s1;
	logic [PW-1:0]            a_s1, b_s1;
	logic                     inside_s1;
	logic signed [LIN_W-1:0]  lin_s1;

	always_ff @(posedge clk) begin
		ab_s1     <= chan_a * chan_b;
		p_a_ba_s1 <= chan_a * alpha_b;
		p_a_ib_s1 <= chan_a * inv_alpha_b;
		p_b_ia_s1 <= chan_b * inv_alpha_a;
		a_s1      <= chan_a;
		b_s1      <= chan_b;
		inside_s1 <= in_region;
		lin_s1    <= k_first * $signed({1'b0, chan_a}) + k_second * $signed({1'b0, chan_b});
	end

	// stage 2: rounded /255 terms, weighted arithmetic terms
	logic [PW-1:0]              m_a_ba_s2, m_a_ib_s2, m_b_ia_s2, a_s2, b_s2;
	logic                       inside_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [LIN255_W-1:0] lin255_s2;
	logic signed [OFF_W-1:0]    off_s2;

	always_ff @(posedge clk) begin
		m_a_ba_s2 <= div255_round(p_a_ba_s1);
		m_a_ib_s2 <= div255_round(p_a_ib_s1);
		m_b_ia_s2 <= div255_round(p_b_ia_s1);
		a_s2      <= a_s1;
		b_s2      <= b_s1;
		inside_s2 <= inside_s1;
		prod_s2   <= k_product * $signed({1'b0, ab_s1});
		lin255_s2 <= (LIN255_W'(lin_s1) <<< 8) - LIN255_W'(lin_s1);
		off_s2    <= (OFF_W'(k_offset) <<< 16) - (OFF_W'(k_offset) <<< 9) + OFF_W'(k_offset);
	end

	// stage 3: Porter-Duff select and saturate; numerator sum
	logic [PW:0]            pd_sum;
	logic [PW-1:0]          pd_res;
	logic [PW-1:0]          pd_s3;
	logic signed [N_W-1:0]  n_s3;

	always_comb begin
		unique case (mode)
			svgcpb_pkg::MODE_OVER: pd_sum = {1'b0, a_s2} + {1'b0, m_b_ia_s2};
			svgcpb_pkg::MODE_IN:   pd_sum = {1'b0, m_a_ba_s2};
			svgcpb_pkg::MODE_OUT:  pd_sum = {1'b0, m_a_ib_s2};
			svgcpb_pkg::MODE_ATOP: pd_sum = {1'b0, m_a_ba_s2} + {1'b0, m_b_ia_s2};
			svgcpb_pkg::MODE_XOR:  pd_sum = {1'b0, m_a_ib_s2} + {1'b0, m_b_ia_s2};
			default:               pd_sum = {1'b0, b_s2} + {1'b0, m_a_ib_s2};
		endcase
		if (!inside_s2) begin
			pd_res = a_s2;
		end else if (pd_sum[PW]) begin
			pd_res = 8'hFF;
		end else begin
			pd_res = pd_sum[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		pd_s3 <= pd_res;
		n_s3  <= N_W'(prod_s2) + N_W'(lin255_s2) + N_W'(off_s2);
	end

	// stage 4: fold sign so that floor division works on a magnitude
	logic [X_W-1:0] x_s4;
	logic           neg_s4;

	always_ff @(posedge clk) begin
		neg_s4 <= n_s3[N_W-1];
		if (n_s3[N_W-1]) begin
			x_s4 <= X_W'(-n_s3 + N_W'(svgcpb_pkg::DIV_D - 1));
		end else begin
			x_s4 <= X_W'(n_s3);
		end
	end

	// stage 5: reciprocal partial products
	logic [PP_W-1:0] ph_s5, pl_s5;
	logic [X_W-1:0]  x_s5;
	logic            neg_s5;

	always_ff @(posedge clk) begin
		ph_s5  <= x_s4[X_W-1:X_HALF] * svgcpb_pkg::DIV_RECIP;
		pl_s5  <= x_s4[X_HALF-1:0] * svgcpb_pkg::DIV_RECIP;
		x_s5   <= x_s4;
		neg_s5 <= neg_s4;
	end

	// stage 6: quotient estimate, low by at most one
	logic [EST_W-1:0] est_sum;
	logic [Q_W-1:0]   q_s6;
	logic [X_W-1:0]   x_s6;
	logic             neg_s6;

	assign est_sum = {1'b0, ph_s5, {X_HALF{1'b0}}} + EST_W'(pl_s5);

	always_ff @(posedge clk) begin
		q_s6   <= est_sum[X_W +: Q_W];
		x_s6   <= x_s5;
		neg_s6 <= neg_s5;
	end

	// stage 7: back-multiply
	logic [QD_W-1:0] qd_s7;
	logic [Q_W-1:0]  q_s7;
	logic [X_W-1:0]  x_s7;
	logic            neg_s7;

	always_ff @(posedge clk) begin
		qd_s7  <= q_s6 * DIV_D16;
		q_s7   <= q_s6;
		x_s7   <= x_s6;
		neg_s7 <= neg_s6;
	end

	// stage 8: correct the estimate
	logic [X_W:0]   rem;
	logic [Q_W-1:0] q_s8;
	logic           neg_s8;

	assign rem = {1'b0, x_s7} - (X_W+1)'(qd_s7);

	always_ff @(posedge clk) begin
		q_s8   <= q_s7 + Q_W'(rem >= (X_W+1)'(svgcpb_pkg::DIV_D));
		neg_s8 <= neg_s7;
	end

	// stage 9: restore sign
	logic signed [svgcpb_pkg::V_W-1:0] val_s9;
	logic [PW-1:0]                     pd_dly_q [PD_DLY];

	always_ff @(posedge clk) begin
		if (neg_s8) begin
			val_s9 <= -$signed(q_s8);
		end else begin
			val_s9 <= $signed(q_s8);
		end
		pd_dly_q[0] <= pd_s3;
		for (int i = 1; i < PD_DLY; i++) begin
			pd_dly_q[i] <= pd_dly_q[i-1];
		end
	end

	assign arith_val = val_s9;
	assign blend     = pd_dly_q[PD_DLY-1];

endmodule

// ===== design/svgcpb_merge.sv =====
module svgcpb_merge #(
	parameter int unsigned COEF_FRAC_BITS = svgcpb_pkg::COEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  svgcpb_pkg::ctrl_t                 ctrl_in,
	input  logic signed [svgcpb_pkg::V_W-1:0] arith_val [svgcpb_pkg::LANES],
	input  logic [svgcpb_pkg::PIX_W-1:0]      blend [svgcpb_pkg::LANES],
	output logic                              res_valid,
	output svgcpb_pkg::pixel_t                res
);

	localparam int unsigned LANES  = svgcpb_pkg::LANES;
	localparam int unsigned COLS   = LANES - 1;
	localparam int unsigned PW     = svgcpb_pkg::PIX_W;
	localparam int unsigned V_W    = svgcpb_pkg::V_W;
	localparam int unsigned S_W    = V_W + 8;
	localparam int unsigned S_LO_W = S_W / 2;
	localparam int unsigned PL_W   = V_W + S_LO_W + 1;
	localparam int unsigned PH_W   = V_W + S_W - S_LO_W;
	localparam int unsigned PROD_W = V_W + S_W;

	svgcpb_pkg::ctrl_t ctrl_m1, ctrl_m2, ctrl_m3, ctrl_m4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_m1 <= '0;
			ctrl_m2 <= '0;
			ctrl_m3 <= '0;
			ctrl_m4 <= '0;
		end else begin
			ctrl_m1 <= ctrl_in;
			ctrl_m2 <= ctrl_m1;
			ctrl_m3 <= ctrl_m2;
			ctrl_m4 <= ctrl_m3;
		end
	end

	// m1: scaled alpha S = 255 * v_alpha
	logic signed [S_W-1:0] s_m1;
	logic signed [V_W-1:0] vc_m1 [COLS];
	logic [PW-1:0]         blend_m1 [LANES];
	logic [PW-1:0]         blend_m2 [LANES];
	logic [PW-1:0]         blend_m3 [LANES];

	always_ff @(posedge clk) begin
		s_m1 <= (S_W'(arith_val[0]) <<< 8) - S_W'(arith_val[0]);
		for (int c = 0; c < COLS; c++) begin
			vc_m1[c] <= arith_val[c+1];
		end
		for (int l = 0; l < LANES; l++) begin
			blend_m1[l] <= blend[l];
			blend_m2[l] <= blend_m1[l];
			blend_m3[l] <= blend_m2[l];
		end
	end

	// m2: alpha result; color times S in two partial products
	logic signed [S_W-1:0]  alpha_sh;
	logic [PW-1:0]          alpha_sat;
	logic [PW-1:0]          alpha_m2, alpha_m3;
	logic signed [PL_W-1:0] pl_m2 [COLS];
	logic signed [PH_W-1:0] ph_m2 [COLS];

	always_comb begin
		alpha_sh = s_m1 >>> COEF_FRAC_BITS;
		if (s_m1[S_W-1] || s_m1 == '0) begin
			alpha_sat = '0;
		end else if (|alpha_sh[S_W-1:PW]) begin
			alpha_sat = 8'hFF;
		end else begin
			alpha_sat = alpha_sh[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		alpha_m2 <= alpha_sat;
		alpha_m3 <= alpha_m2;
		for (int c = 0; c < COLS; c++) begin
			pl_m2[c] <= vc_m1[c] * $signed({1'b0, s_m1[S_LO_W-1:0]});
			ph_m2[c] <= vc_m1[c] * $signed(s_m1[S_W-1:S_LO_W]);
		end
	end

	// m3: join partial products
	logic signed [PROD_W-1:0] prod_m3 [COLS];

	always_ff @(posedge clk) begin
		for (int c = 0; c < COLS; c++) begin
			prod_m3[c] <= (PROD_W'(ph_m2[c]) <<< S_LO_W) + PROD_W'(pl_m2[c]);
		end
	end

	// m4: saturate color, pick arithmetic or blend result
	logic signed [PROD_W-1:0] col_sh [COLS];
	logic [PW-1:0]            col_sat [COLS];
	svgcpb_pkg::pixel_t       pix_next;
	svgcpb_pkg::pixel_t       res_m4;

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			col_sh[c] = prod_m3[c] >>> (2 * COEF_FRAC_BITS);
			if (prod_m3[c][PROD_W-1] || prod_m3[c] == '0) begin
				col_sat[c] = '0;
			end else if (|col_sh[c][PROD_W-1:PW]) begin
				col_sat[c] = 8'hFF;
			end else begin
				col_sat[c] = col_sh[c][PW-1:0];
			end
		end
		if (ctrl_m3.arith) begin
			pix_next = '{alpha: alpha_m3, red: col_sat[0], green: col_sat[1],
				blue: col_sat[2]};
		end else begin
			pix_next = '{alpha: blend_m3[0], red: blend_m3[1], green: blend_m3[2],
				blue: blend_m3[3]};
		end
	end

	always_ff @(posedge clk) begin
		res_m4 <= pix_next;
	end

	assign res_valid = ctrl_m4.valid;
	assign res       = res_m4;

endmodule

// ===== design/svgcpb_queue.sv =====
module svgcpb_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  svgcpb_pkg::pixel_t                push_data,
	input  logic                              pop,
	output logic                              not_empty,
	output svgcpb_pkg::pixel_t                head,
	output logic [svgcpb_pkg::QUEUE_AW:0]     level
);

	localparam int unsigned AW = svgcpb_pkg::QUEUE_AW;

	svgcpb_pkg::pixel_t mem_q [svgcpb_pkg::QUEUE_DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [AW:0]        level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign not_empty = (level_q != '0);
	assign head      = mem_q[rd_q];
	assign level     = level_q;

endmodule

// ===== design/svg_composite_pixel_blender_top.sv =====
// Composites one pair of premultiplied ARGB8 pixels per item and returns one
// pixel per item, in order. An item can be taken in every clock cycle while
// in_ready is high; its result passes through the four channel lanes, where
// the arithmetic mode's floor division by 255*255 is done by a reciprocal
// multiply and one correction step, then through the merge stage, which
// scales the color lanes by the alpha lane, into the output queue. Results
// wait in a 32-entry queue, so input keeps flowing while a result is not
// taken; in_ready drops only when 32 accepted items have not yet been read
// out. The register port is always ready; write it only while no item is in
// flight. Outside the filter region the first pixel is returned unchanged.
module svg_composite_pixel_blender_top #(
	parameter int unsigned COEF_FRAC_BITS = svgcpb_pkg::COEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svgcpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svgcpb_pkg::COEF_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [svgcpb_pkg::PIX_W-1:0]         first_alpha,
	input  logic [svgcpb_pkg::PIX_W-1:0]         first_red,
	input  logic [svgcpb_pkg::PIX_W-1:0]         first_green,
	input  logic [svgcpb_pkg::PIX_W-1:0]         first_blue,
	input  logic [svgcpb_pkg::PIX_W-1:0]         second_alpha,
	input  logic [svgcpb_pkg::PIX_W-1:0]         second_red,
	input  logic [svgcpb_pkg::PIX_W-1:0]         second_green,
	input  logic [svgcpb_pkg::PIX_W-1:0]         second_blue,
	input  logic                                 inside_region,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [svgcpb_pkg::PIX_W-1:0]         out_alpha,
	output logic [svgcpb_pkg::PIX_W-1:0]         out_red,
	output logic [svgcpb_pkg::PIX_W-1:0]         out_green,
	output logic [svgcpb_pkg::PIX_W-1:0]         out_blue
);

	localparam int unsigned LANES    = svgcpb_pkg::LANES;
	localparam int unsigned LANE_LAT = svgcpb_pkg::LANE_LAT;
	localparam int unsigned CNT_W    = svgcpb_pkg::QUEUE_AW + 1;

	logic [svgcpb_pkg::MODE_W-1:0]        mode_q;
	logic signed [svgcpb_pkg::COEF_W-1:0] coef_product_q, coef_first_q;
	logic signed [svgcpb_pkg::COEF_W-1:0] coef_second_q, coef_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= svgcpb_pkg::MODE_OVER;
			coef_product_q <= '0;
			coef_first_q   <= '0;
			coef_second_q  <= '0;
			coef_offset_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				svgcpb_pkg::REG_MODE:         mode_q <= cfg_data[svgcpb_pkg::MODE_W-1:0];
				svgcpb_pkg::REG_COEF_PRODUCT: coef_product_q <= $signed(cfg_data);
				svgcpb_pkg::REG_COEF_FIRST:   coef_first_q <= $signed(cfg_data);
				svgcpb_pkg::REG_COEF_SECOND:  coef_second_q <= $signed(cfg_data);
				svgcpb_pkg::REG_COEF_OFFSET:  coef_offset_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	logic in_fire, out_fire;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (cnt_q != CNT_W'(svgcpb_pkg::QUEUE_DEPTH));
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// count items accepted and not yet read out; bounds queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({in_fire, out_fire})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	svgcpb_pkg::ctrl_t ctrl_dly_q [LANE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				ctrl_dly_q[i] <= '0;
			end
		end else begin
			ctrl_dly_q[0] <= '{valid: in_fire,
				arith: inside_region && (mode_q == svgcpb_pkg::MODE_ARITH)};
			for (int i = 1; i < LANE_LAT; i++) begin
				ctrl_dly_q[i] <= ctrl_dly_q[i-1];
			end
		end
	end

	logic [svgcpb_pkg::PIX_W-1:0]        chan_a [LANES];
	logic [svgcpb_pkg::PIX_W-1:0]        chan_b [LANES];
	logic [svgcpb_pkg::PIX_W-1:0]        blend [LANES];
	logic signed [svgcpb_pkg::V_W-1:0]   arith_val [LANES];

	assign chan_a[0] = first_alpha;
	assign chan_a[1] = first_red;
	assign chan_a[2] = first_green;
	assign chan_a[3] = first_blue;
	assign chan_b[0] = second_alpha;
	assign chan_b[1] = second_red;
	assign chan_b[2] = second_green;
	assign chan_b[3] = second_blue;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		svgcpb_lane u_lane (
			.clk       (clk),
			.chan_a    (chan_a[l]),
			.chan_b    (chan_b[l]),
			.alpha_a   (first_alpha),
			.alpha_b   (second_alpha),
			.in_region (inside_region),
			.mode      (mode_q),
			.k_product (coef_product_q),
			.k_first   (coef_first_q),
			.k_second  (coef_second_q),
			.k_offset  (coef_offset_q),
			.blend     (blend[l]),
			.arith_val (arith_val[l])
		);
	end

	logic               res_valid;
	svgcpb_pkg::pixel_t res;

	svgcpb_merge #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_in   (ctrl_dly_q[LANE_LAT-1]),
		.arith_val (arith_val),
		.blend     (blend),
		.res_valid (res_valid),
		.res       (res)
	);

	svgcpb_pkg::pixel_t head;
	logic [CNT_W-1:0]   q_level;

	svgcpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_fire),
		.not_empty (out_valid),
		.head      (head),
		.level     (q_level)
	);

	assign out_alpha = head.alpha;
	assign out_red   = head.red;
	assign out_green = head.green;
	assign out_blue  = head.blue;

`ifndef SYNTH
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(svgcpb_pkg::QUEUE_DEPTH))
		else $error("outstanding item count above queue depth");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> q_level != CNT_W'(svgcpb_pkg::QUEUE_DEPTH))
		else $error("result pushed into a full queue");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= cnt_q)
		else $error("queue holds more results than items outstanding");

	a_credit_track: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !out_fire) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted item not counted");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import svgcpb_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

	localparam logic [COEF_W-1:0] K_ZERO = 24'h000000;
	localparam logic [COEF_W-1:0] K_ONE = 24'(1 << COEF_FRAC_BITS);
	localparam logic [COEF_W-1:0] K_HALF = 24'(1 << (COEF_FRAC_BITS - 1));
	localparam logic [COEF_W-1:0] K_NEG_ONE = K_ZERO - K_ONE;
	localparam logic [COEF_W-1:0] K_MAX = 24'h7fffff;
	localparam logic [COEF_W-1:0] K_MIN = 24'h800000;

	localparam int unsigned RAND_PHASES = 23;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam int unsigned END_WAIT = 40;
	localparam int unsigned STALL_LIMIT = 4000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [COEF_W-1:0] k_prod;
		logic [COEF_W-1:0] k_first;
		logic [COEF_W-1:0] k_second;
		logic [COEF_W-1:0] k_off;
		pixel_t a;
		pixel_t b;
		logic ins;
		logic known;
		pixel_t want;
	} blend_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] first_alpha = '0;
	logic [PIX_W-1:0] first_red = '0;
	logic [PIX_W-1:0] first_green = '0;
	logic [PIX_W-1:0] first_blue = '0;
	logic [PIX_W-1:0] second_alpha = '0;
	logic [PIX_W-1:0] second_red = '0;
	logic [PIX_W-1:0] second_green = '0;
	logic [PIX_W-1:0] second_blue = '0;
	logic inside_region = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] out_alpha;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;

	// shadow of the register file
	logic [MODE_W-1:0] cur_mode = MODE_OVER;
	logic signed [COEF_W-1:0] k_product = '0;
	logic signed [COEF_W-1:0] k_first = '0;
	logic signed [COEF_W-1:0] k_second = '0;
	logic signed [COEF_W-1:0] k_offset = '0;

	pixel_t blend_expected [$];
	pixel_t want_px;
	int unsigned mismatches = 0;
	int unsigned stall_run = 0;
	bit no_gaps = 1'b0;

	blend_case_t directed_cases [23] = '{
		'{MODE_OVER, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h00000000, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
		'{MODE_OVER, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hff123456, 32'h89abcdef, 1'b0, 1'b1, 32'hff123456},
		'{MODE_OVER, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
		'{MODE_OVER, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h00000000, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
		'{MODE_OVER, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h80402010, 32'hc0a06040, 1'b1, 1'b0, 32'h00000000},
		'{MODE_IN, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'h00ffffff, 1'b1, 1'b1, 32'h00000000},
		'{MODE_IN, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'hff000000, 1'b1, 1'b1, 32'hffffffff},
		'{MODE_OUT, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'hff000000, 1'b1, 1'b1, 32'h00000000},
		'{MODE_OUT, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h7f3f1f0f, 32'h40102030, 1'b1, 1'b0, 32'h00000000},
		'{MODE_ATOP, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'ha0806040, 32'hff203040, 1'b1, 1'b0, 32'h00000000},
		'{MODE_XOR, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 32'h00000000},
		'{MODE_XOR, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h00ffffff, 32'h00ffffff, 1'b1, 1'b1, 32'h00ffffff},
		'{MODE_SPARE6, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'h00000000, 32'h12345678, 1'b1, 1'b1, 32'h12345678},
		'{MODE_SPARE7, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hc0804020, 32'h40302010, 1'b1, 1'b0, 32'h00000000},
		'{MODE_ARITH, K_ZERO, K_ZERO, K_ZERO, K_ZERO,
			32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 32'h00000000},
		'{MODE_ARITH, K_ZERO, K_ZERO, K_ZERO, K_ONE,
			32'h00000000, 32'h00000000, 1'b1, 1'b1, 32'hffffffff},
		'{MODE_ARITH, K_ZERO, K_ONE, K_ZERO, K_ZERO,
			32'hffffffff, 32'h00000000, 1'b1, 1'b1, 32'hffffffff},
		'{MODE_ARITH, K_ZERO, K_ZERO, K_ZERO, K_MAX,
			32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1, 1'b1, 32'hffffffff},
		// negative alpha and negative colour multiply to a positive colour
		'{MODE_ARITH, K_ZERO, K_ZERO, K_ZERO, K_MIN,
			32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1, 1'b1, 32'h00ffffff},
		'{MODE_ARITH, K_MAX, K_MIN, K_MAX, K_ZERO,
			32'hffffffff, 32'h80808080, 1'b1, 1'b0, 32'h00000000},
		'{MODE_ARITH, K_MIN, K_MAX, K_MIN, K_MAX,
			32'h7f7f7f7f, 32'hffffffff, 1'b1, 1'b0, 32'h00000000},
		'{MODE_ARITH, K_ZERO, K_ZERO, K_NEG_ONE, K_HALF,
			32'h00000000, 32'h00ff0080, 1'b1, 1'b0, 32'h00000000},
		'{MODE_ARITH, K_ZERO, K_ZERO, K_ZERO, K_ONE,
			32'h11223344, 32'hffffffff, 1'b0, 1'b1, 32'h11223344}
	};

	svg_composite_pixel_blender_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_alpha  (first_alpha),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_alpha (second_alpha),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.inside_region(inside_region),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_alpha    (out_alpha),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned mul255(input int unsigned x, input int unsigned y);
		return (x * y + 127) / 255;
	endfunction

	// one arithmetic-mode channel, floor(N / 255^2) in units of 2^-F
	function automatic longint lane_value(input longint a, input longint b);
		longint n;
		n = longint'(k_product) * a * b
			+ 255 * (longint'(k_first) * a + longint'(k_second) * b)
			+ 65025 * longint'(k_offset);
		if (n >= 0)
			return n / 65025;
		return -((-n + 65024) / 65025);
	endfunction

	function automatic logic [PIX_W-1:0] clip_shift(input longint p, input int unsigned sh);
		longint q;
		if (p <= 0)
			return '0;
		q = p >>> sh;
		return (q > 255) ? 8'd255 : q[PIX_W-1:0];
	endfunction

	function automatic pixel_t blend_pixel(input pixel_t a, input pixel_t b, input logic ins);
		logic [PIX_W-1:0] av [4];
		logic [PIX_W-1:0] bv [4];
		logic [PIX_W-1:0] rv [4];
		int unsigned ia;
		int unsigned ib;
		int unsigned v;
		longint s;
		pixel_t r;
		av = '{a.alpha, a.red, a.green, a.blue};
		bv = '{b.alpha, b.red, b.green, b.blue};
		if (!ins)
			return a;
		if (cur_mode == MODE_ARITH) begin
			s = 255 * lane_value(av[0], bv[0]);
			rv[0] = clip_shift(s, COEF_FRAC_BITS);
			for (int i = 1; i < 4; i++)
				rv[i] = clip_shift(lane_value(av[i], bv[i]) * s, 2 * COEF_FRAC_BITS);
		end else begin
			ia = 255 - av[0];
			ib = 255 - bv[0];
			for (int i = 0; i < 4; i++) begin
				case (cur_mode)
					MODE_OVER: v = av[i] + mul255(bv[i], ia);
					MODE_IN:   v = mul255(av[i], bv[0]);
					MODE_OUT:  v = mul255(av[i], ib);
					MODE_ATOP: v = mul255(av[i], bv[0]) + mul255(bv[i], ia);
					MODE_XOR:  v = mul255(av[i], ib) + mul255(bv[i], ia);
					// spare codes draw the second pixel over the first
					default:   v = bv[i] + mul255(av[i], ib);
				endcase
				rv[i] = (v > 255) ? 8'd255 : v[PIX_W-1:0];
			end
		end
		r.alpha = rv[0];
		r.red = rv[1];
		r.green = rv[2];
		r.blue = rv[3];
		return r;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return K_MAX;
			1: return K_MIN;
			2: return K_ZERO;
			3, 4: return COEF_W'($urandom);
			default: return COEF_W'($urandom_range(0, 4 * K_ONE)) - (K_ONE << 1);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int unsigned r;
		if ($urandom_range(0, 3) == 0)
			return pixel_t'($urandom);
		r = $urandom_range(0, 7);
		p.alpha = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : PIX_W'($urandom);
		// premultiplied: colour never above alpha
		p.red = PIX_W'($urandom_range(0, p.alpha));
		p.green = PIX_W'($urandom_range(0, p.alpha));
		p.blue = PIX_W'($urandom_range(0, p.alpha));
		return p;
	endfunction

	function automatic void check_lane(input string name, input logic [PIX_W-1:0] exp_v,
			input logic [PIX_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:         cur_mode = data[MODE_W-1:0];
			REG_COEF_PRODUCT: k_product = data;
			REG_COEF_FIRST:   k_first = data;
			REG_COEF_SECOND:  k_second = data;
			REG_COEF_OFFSET:  k_offset = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// drain the pipeline, then reprogram; only while nothing is in flight
	task automatic apply_setting(input logic [MODE_W-1:0] m, input logic [COEF_W-1:0] c1,
			input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3,
			input logic [COEF_W-1:0] c4, input bit write_all, input bit junk);
		if (!write_all && m == cur_mode && c1 == k_product && c2 == k_first
				&& c3 == k_second && c4 == k_offset)
			return;
		in_valid <= 1'b0;
		while (blend_expected.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		if (write_all || m != cur_mode)
			write_reg(REG_MODE, {(COEF_W - MODE_W)'($urandom), m});
		if (write_all || c1 != k_product)
			write_reg(REG_COEF_PRODUCT, c1);
		if (write_all || c2 != k_first)
			write_reg(REG_COEF_FIRST, c2);
		if (write_all || c3 != k_second)
			write_reg(REG_COEF_SECOND, c3);
		if (write_all || c4 != k_offset)
			write_reg(REG_COEF_OFFSET, c4);
		if (junk)
			write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
				COEF_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input pixel_t a, input pixel_t b, input logic ins,
			input logic known, input pixel_t want);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		first_alpha <= a.alpha;
		first_red <= a.red;
		first_green <= a.green;
		first_blue <= a.blue;
		second_alpha <= b.alpha;
		second_red <= b.red;
		second_green <= b.green;
		second_blue <= b.blue;
		inside_region <= ins;
		do @(posedge clk); while (!in_ready);
		blend_expected.push_back(known ? want : blend_pixel(a, b, ins));
		@(negedge clk);
	endtask

	// result side: random stalls of out_ready
	initial begin
		int unsigned gap;
		@(negedge clk);
		forever begin
			gap = idle_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (blend_expected.size() == 0) begin
				$error("result item with nothing pending");
				mismatches++;
			end else begin
				want_px = blend_expected.pop_front();
				check_lane("out_alpha", want_px.alpha, out_alpha);
				check_lane("out_red", want_px.red, out_red);
				check_lane("out_green", want_px.green, out_green);
				check_lane("out_blue", want_px.blue, out_blue);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
		if (stall_run >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [MODE_W-1:0] pm;
		int unsigned r;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_cases[i]) begin
			apply_setting(directed_cases[i].mode, directed_cases[i].k_prod,
				directed_cases[i].k_first, directed_cases[i].k_second,
				directed_cases[i].k_off, 1'b0, 1'b0);
			send_pixel(directed_cases[i].a, directed_cases[i].b, directed_cases[i].ins,
				directed_cases[i].known, directed_cases[i].want);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			r = $urandom_range(0, 9);
			pm = (r >= 8) ? MODE_ARITH : MODE_W'(r);
			apply_setting(pm, random_coef(), random_coef(), random_coef(), random_coef(),
				1'b1, $urandom_range(0, 2) == 0);
			no_gaps = ($urandom_range(0, 4) == 0);
			repeat (PHASE_ITEMS)
				send_pixel(random_pixel(), random_pixel(), $urandom_range(0, 7) != 0,
					1'b0, '0);
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		while (blend_expected.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
